// ----- sv/khmt_pkg.sv -----
`timescale 1ns / 1ps
// khmt_pkg: shared types and constants of the killer/history move table
// no dependencies; used by every file of the block except khmt_ram

package khmt_pkg;

  localparam int DEPTH_SLOTS_DEF = 64;
  localparam int CELLS_DEF       = 225;
  localparam int HIST_BITS_DEF   = 24;

  localparam logic [7:0]  NO_MOVE      = 8'hFF;
  localparam logic [19:0] FIRST_SCORE  = 20'd900000;
  localparam logic [19:0] SECOND_SCORE = 20'd800000;
  localparam logic [19:0] HISTORY_CAP  = 20'd700000;

  typedef enum logic [2:0] {
    MODE_ADD_KILLER  = 3'd0,
    MODE_ADD_HISTORY = 3'd1,
    MODE_AGE         = 3'd2,
    MODE_SCORE       = 3'd3,
    MODE_CLEAR       = 3'd4
  } mode_e;

  // one latched request with its precomputed checks
  typedef struct packed {
    logic [2:0]  mode;
    logic [7:0]  cell_idx;
    logic [7:0]  depth;
    logic [14:0] sq;
    logic        cell_ok;
    logic        depth_ok;
  } item_t;

  // write strobes from the update datapath
  typedef struct packed {
    logic kill_we;
    logic hist_we;
    logic score_vld;
  } upd_t;

endpackage

// ----- sv/khmt_ram.sv -----
`timescale 1ns / 1ps
// khmt_ram: generic single-write, single-read ram with registered read data
// no dependencies

module khmt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/khmt_alu.sv -----
`timescale 1ns / 1ps
// khmt_alu: killer update, saturating history add and score selection
// depends on khmt_pkg

module khmt_alu #(
  parameter int HIST_BITS = khmt_pkg::HIST_BITS_DEF
) (
  input  khmt_pkg::item_t       item_i,
  input  logic [15:0]           kword_i,
  input  logic [HIST_BITS-1:0]  hist_i,
  output khmt_pkg::upd_t        upd_o,
  output logic [15:0]           kill_wdata_o,
  output logic [HIST_BITS-1:0]  hist_wdata_o,
  output logic [19:0]           score_o
);

  logic [7:0]         first;
  logic [7:0]         second;
  logic [HIST_BITS:0] sum;
  logic [19:0]        hist_capped;

  assign first  = kword_i[15:8];
  assign second = kword_i[7:0];
  assign sum    = {1'b0, hist_i} + (HIST_BITS + 1)'(item_i.sq);

  assign kill_wdata_o = {item_i.cell_idx, first};
  assign hist_wdata_o = sum[HIST_BITS] ? {HIST_BITS{1'b1}} : sum[HIST_BITS-1:0];
  assign hist_capped  = (hist_i > HIST_BITS'(khmt_pkg::HISTORY_CAP)) ?
                        khmt_pkg::HISTORY_CAP : hist_i[19:0];

  always_comb begin
    upd_o   = '0;
    score_o = '0;
    unique case (khmt_pkg::mode_e'(item_i.mode))
      khmt_pkg::MODE_ADD_KILLER: begin
        upd_o.kill_we = item_i.cell_ok && item_i.depth_ok && (first != item_i.cell_idx);
      end
      khmt_pkg::MODE_ADD_HISTORY: begin
        upd_o.hist_we = item_i.cell_ok;
      end
      khmt_pkg::MODE_SCORE: begin
        upd_o.score_vld = 1'b1;
        priority if (!item_i.cell_ok) begin
          score_o = '0;
        end else if (item_i.depth_ok && first == item_i.cell_idx) begin
          score_o = khmt_pkg::FIRST_SCORE;
        end else if (item_i.depth_ok && second == item_i.cell_idx) begin
          score_o = khmt_pkg::SECOND_SCORE;
        end else begin
          score_o = hist_capped;
        end
      end
      default: begin
        upd_o = '0;
      end
    endcase
  end

endmodule

// ----- sv/killer_history_move_table_core.sv -----
`timescale 1ns / 1ps
// killer_history_move_table_core: top level of the move-ordering score table
// depends on khmt_pkg, khmt_ram, khmt_alu

// Killer/history move-ordering table. Killer slots (first and second per
// depth) sit in one ram, history counters (one per cell) in another; both
// rams have registered read data. Add-killer, add-history and score issue
// their read in the accept cycle; the write-back or result follows in the
// exec state, after which a new request is taken. Clear-killers and the
// unused modes leave the sequencer idle. Age walks the history ram one entry
// per cycle with a pipelined read and halved write-back, so ready returns
// only after the sweep has passed every entry and the age-end state.
// Entries carry valid bits in flip-flops, so reset needs no clearing pass
// and clear-killers completes at once. A score waits in the exec state
// only while an earlier score still sits unclaimed in the output register.

module killer_history_move_table_core #(
  parameter int DEPTH_SLOTS = khmt_pkg::DEPTH_SLOTS_DEF,
  parameter int CELLS       = khmt_pkg::CELLS_DEF,
  parameter int HIST_BITS   = khmt_pkg::HIST_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [2:0]        mode_i,
  input  logic [7:0]        cell_req_i,
  input  logic signed [7:0] ply_depth_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [19:0]       score_o
);

  localparam int KAW = (DEPTH_SLOTS > 1) ? $clog2(DEPTH_SLOTS) : 1;
  localparam int HAW = $clog2(CELLS);

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE    = 4'b0001,
    ST_EXEC    = 4'b0010,
    ST_AGE     = 4'b0100,
    ST_AGE_END = 4'b1000
  } state_e;

  state_e state_q, state_d;

  khmt_pkg::item_t item_q, item_d;
  logic            accept;
  logic [7:0]      depth_u;
  logic signed [15:0] sq_full;

  // valid bits: an entry that is not valid reads as its reset value
  logic [DEPTH_SLOTS-1:0] kvalid_q, kvalid_d;
  logic [CELLS-1:0]       hvalid_q, hvalid_d;

  // age sweep: read pointer and delayed write pointer
  logic [HAW-1:0] age_ptr_q, age_ptr_d;
  logic [HAW-1:0] age_wptr_q, age_wptr_d;
  logic           age_wv_q, age_wv_d;

  // output register
  logic        out_valid_q, out_valid_d;
  logic [19:0] score_q, score_d;

  // ram ports
  logic [KAW-1:0]       kill_raddr;
  logic [15:0]          kill_rdata;
  logic                 kill_we;
  logic [15:0]          kill_wdata;
  logic [HAW-1:0]       hist_raddr;
  logic [HIST_BITS-1:0] hist_rdata;
  logic                 hist_we;
  logic [HAW-1:0]       hist_waddr;
  logic [HIST_BITS-1:0] hist_wdata;

  // datapath
  logic [15:0]          kword;
  logic [HIST_BITS-1:0] hist_cur;
  logic [HIST_BITS-1:0] hist_aged;
  khmt_pkg::upd_t       upd;
  logic [15:0]          alu_kill_wdata;
  logic [HIST_BITS-1:0] alu_hist_wdata;
  logic [19:0]          alu_score;
  logic                 exec_go;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  // request checks and depth square, latched at accept
  assign depth_u = ply_depth_i;
  assign sq_full = ply_depth_i * ply_depth_i;

  always_comb begin
    item_d          = item_q;
    if (accept) begin
      item_d.mode     = mode_i;
      item_d.cell_idx = cell_req_i;
      item_d.depth    = depth_u;
      item_d.sq       = sq_full[14:0];
      item_d.cell_ok  = cell_req_i < 8'(CELLS);
      item_d.depth_ok = !depth_u[7] && (depth_u < 8'(DEPTH_SLOTS));
    end
  end

  // read addresses come straight from the ports in the accept cycle and
  // from the latched request while it is being executed
  always_comb begin
    if (state_q == ST_IDLE) begin
      kill_raddr = depth_u[KAW-1:0];
      hist_raddr = cell_req_i[HAW-1:0];
    end else if (state_q == ST_AGE) begin
      kill_raddr = item_q.depth[KAW-1:0];
      hist_raddr = age_ptr_q;
    end else begin
      kill_raddr = item_q.depth[KAW-1:0];
      hist_raddr = item_q.cell_idx[HAW-1:0];
    end
  end

  // substitute reset values for entries never written
  assign kword    = kvalid_q[item_q.depth[KAW-1:0]] ?
                    kill_rdata : {khmt_pkg::NO_MOVE, khmt_pkg::NO_MOVE};
  assign hist_cur = hvalid_q[item_q.cell_idx[HAW-1:0]] ? hist_rdata : '0;

  // halved counter for the age sweep, data belongs to age_wptr_q
  assign hist_aged = hvalid_q[age_wptr_q] ? (hist_rdata >> 1) : '0;

  khmt_alu #(
    .HIST_BITS(HIST_BITS)
  ) u_alu (
    .item_i      (item_q),
    .kword_i     (kword),
    .hist_i      (hist_cur),
    .upd_o       (upd),
    .kill_wdata_o(alu_kill_wdata),
    .hist_wdata_o(alu_hist_wdata),
    .score_o     (alu_score)
  );

  // a score may only leave when the output register is free
  assign exec_go = !upd.score_vld || !out_valid_q || out_ready_i;

  // write-back: exec and age sweep never overlap
  always_comb begin
    kill_we    = (state_q == ST_EXEC) && exec_go && upd.kill_we;
    kill_wdata = alu_kill_wdata;
    if (age_wv_q) begin
      hist_we    = 1'b1;
      hist_waddr = age_wptr_q;
      hist_wdata = hist_aged;
    end else begin
      hist_we    = (state_q == ST_EXEC) && exec_go && upd.hist_we;
      hist_waddr = item_q.cell_idx[HAW-1:0];
      hist_wdata = alu_hist_wdata;
    end
  end

  khmt_ram #(
    .WIDTH(16),
    .DEPTH(DEPTH_SLOTS)
  ) u_kill_ram (
    .clk_i  (clk_i),
    .we_i   (kill_we),
    .waddr_i(item_q.depth[KAW-1:0]),
    .wdata_i(kill_wdata),
    .raddr_i(kill_raddr),
    .rdata_o(kill_rdata)
  );

  khmt_ram #(
    .WIDTH(HIST_BITS),
    .DEPTH(CELLS)
  ) u_hist_ram (
    .clk_i  (clk_i),
    .we_i   (hist_we),
    .waddr_i(hist_waddr),
    .wdata_i(hist_wdata),
    .raddr_i(hist_raddr),
    .rdata_o(hist_rdata)
  );

  // sequencer
  always_comb begin
    state_d     = state_q;
    kvalid_d    = kvalid_q;
    hvalid_d    = hvalid_q;
    age_ptr_d   = age_ptr_q;
    age_wptr_d  = age_wptr_q;
    age_wv_d    = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    score_d     = score_q;

    if (kill_we) begin
      kvalid_d[item_q.depth[KAW-1:0]] = 1'b1;
    end
    if (hist_we) begin
      hvalid_d[hist_waddr] = 1'b1;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (khmt_pkg::mode_e'(mode_i))
            khmt_pkg::MODE_ADD_KILLER,
            khmt_pkg::MODE_ADD_HISTORY,
            khmt_pkg::MODE_SCORE: begin
              state_d = ST_EXEC;
            end
            khmt_pkg::MODE_AGE: begin
              state_d   = ST_AGE;
              age_ptr_d = '0;
            end
            khmt_pkg::MODE_CLEAR: begin
              kvalid_d = '0;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_EXEC: begin
        if (exec_go) begin
          state_d = ST_IDLE;
          if (upd.score_vld) begin
            out_valid_d = 1'b1;
            score_d     = alu_score;
          end
        end
      end
      ST_AGE: begin
        age_wv_d   = 1'b1;
        age_wptr_d = age_ptr_q;
        age_ptr_d  = age_ptr_q + 1'b1;
        if (age_ptr_q == HAW'(CELLS - 1)) begin
          state_d = ST_AGE_END;
        end
      end
      ST_AGE_END: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      kvalid_q    <= '0;
      hvalid_q    <= '0;
      age_ptr_q   <= '0;
      age_wv_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      kvalid_q    <= kvalid_d;
      hvalid_q    <= hvalid_d;
      age_ptr_q   <= age_ptr_d;
      age_wv_q    <= age_wv_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    item_q     <= item_d;
    age_wptr_q <= age_wptr_d;
    score_q    <= score_d;
  end

  assign out_valid_o = out_valid_q;
  assign score_o     = score_q;

endmodule

// ----- sv/khmt_checker.sv -----
`timescale 1ns / 1ps
// khmt_checker: port-level assertions for the move table, bound to the top
// depends on khmt_pkg and killer_history_move_table_core

module khmt_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic [2:0]        mode_i,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic [19:0]       score_o
);

  logic acc;
  assign acc = in_valid_i && in_ready_o;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(score_o))
    else $error("result changed while stalled");

  // a new result appears only after an accepted score request
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |->
      $past(in_valid_i && in_ready_o && mode_i == khmt_pkg::MODE_SCORE, 2))
    else $error("result without score request");

  // table operations leave the block busy once accepted
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && (mode_i == khmt_pkg::MODE_ADD_KILLER || mode_i == khmt_pkg::MODE_ADD_HISTORY ||
            mode_i == khmt_pkg::MODE_SCORE || mode_i == khmt_pkg::MODE_AGE)
    |=> !in_ready_o)
    else $error("ready during table operation");

  // age sweep keeps the block busy longer than the other operations
  a_age_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && mode_i == khmt_pkg::MODE_AGE |-> ##2 !in_ready_o)
    else $error("age sweep ended early");

  // clear finishes in its accept cycle
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && mode_i == khmt_pkg::MODE_CLEAR |=> in_ready_o)
    else $error("clear not single cycle");

endmodule

bind killer_history_move_table_core khmt_checker u_khmt_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .mode_i     (mode_i),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .score_o    (score_o)
);

// ----- tb/tb_killer_history_move_table_core.sv -----
`timescale 1ns / 1ps
// tb_killer_history_move_table_core: self-checking bench for the move-ordering score table
// depends on khmt_pkg and killer_history_move_table_core; a scoreboard class tracks scores

module tb_killer_history_move_table_core;

  localparam int DEPTH_SLOTS = khmt_pkg::DEPTH_SLOTS_DEF;
  localparam int CELLS       = khmt_pkg::CELLS_DEF;
  localparam int HIST_BITS   = khmt_pkg::HIST_BITS_DEF;

  // modes the block treats as no-ops
  localparam logic [2:0] MODE_SPARE_FIRST = 3'd5;
  localparam logic [2:0] MODE_SPARE_LAST  = 3'd7;

  localparam longint HIST_MAX      = (longint'(1) << HIST_BITS) - 1;
  // an age walk may still be running after the last score comes back
  localparam int     SETTLE_CYCLES = CELLS + 16;
  localparam int     TIMEOUT_NS    = 5_000_000;
  localparam int     REPORT_LIMIT  = 10;
  // cell hammered until its history counter saturates
  localparam int     SAT_CELL      = 7;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  logic [2:0]        mode_i;
  logic [7:0]        cell_req_i;
  logic signed [7:0] ply_depth_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic [19:0]       score_o;

  killer_history_move_table_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .mode_i      (mode_i),
    .cell_req_i  (cell_req_i),
    .ply_depth_i (ply_depth_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .score_o     (score_o)
  );

  // shadow copy of the killer and history tables plus the queue of scores in flight
  class move_score_board;
    logic [7:0]           killer_first[DEPTH_SLOTS];
    logic [7:0]           killer_second[DEPTH_SLOTS];
    logic [HIST_BITS-1:0] history_count[CELLS];
    logic [19:0]          pending_scores[$];
    int                   failures;
    int                   requests;
    int                   scores_checked;
    int                   ages;
    int                   clears;
    int                   killer_adds;
    int                   history_adds;

    function new();
      for (int i = 0; i < DEPTH_SLOTS; i++) begin
        killer_first[i]  = khmt_pkg::NO_MOVE;
        killer_second[i] = khmt_pkg::NO_MOVE;
      end
      for (int i = 0; i < CELLS; i++) history_count[i] = '0;
      failures       = 0;
      requests       = 0;
      scores_checked = 0;
      ages           = 0;
      clears         = 0;
      killer_adds    = 0;
      history_adds   = 0;
    endfunction

    // apply one accepted request to the shadow tables
    function void note_request(logic [2:0] m, logic [7:0] c, logic signed [7:0] d);
      int     dv;
      bit     cell_ok;
      bit     depth_ok;
      longint sum;
      logic [19:0] s;
      dv       = int'(d);
      cell_ok  = int'(c) < CELLS;
      depth_ok = dv >= 0 && dv < DEPTH_SLOTS;
      requests++;
      unique case (m)
        khmt_pkg::MODE_ADD_KILLER: begin
          killer_adds++;
          if (cell_ok && depth_ok && killer_first[dv] != c) begin
            killer_second[dv] = killer_first[dv];
            killer_first[dv]  = c;
          end
        end
        khmt_pkg::MODE_ADD_HISTORY: begin
          history_adds++;
          // the square is taken for any depth, negative included
          if (cell_ok) begin
            sum = longint'(history_count[c]) + longint'(dv * dv);
            history_count[c] = (sum > HIST_MAX) ? HIST_MAX[HIST_BITS-1:0]
                                                : sum[HIST_BITS-1:0];
          end
        end
        khmt_pkg::MODE_AGE: begin
          ages++;
          for (int i = 0; i < CELLS; i++) history_count[i] = history_count[i] >> 1;
        end
        khmt_pkg::MODE_SCORE: begin
          s = '0;
          if (cell_ok) begin
            if (depth_ok && killer_first[dv] == c) s = khmt_pkg::FIRST_SCORE;
            else if (depth_ok && killer_second[dv] == c) s = khmt_pkg::SECOND_SCORE;
            else if (history_count[c] > khmt_pkg::HISTORY_CAP) s = khmt_pkg::HISTORY_CAP;
            else s = history_count[c][19:0];
          end
          pending_scores.insert(pending_scores.size(), s);
        end
        khmt_pkg::MODE_CLEAR: begin
          clears++;
          for (int i = 0; i < DEPTH_SLOTS; i++) begin
            killer_first[i]  = khmt_pkg::NO_MOVE;
            killer_second[i] = khmt_pkg::NO_MOVE;
          end
        end
        default: ;
      endcase
    endfunction

    function void note_failure(string what);
      failures++;
      if (failures <= REPORT_LIMIT) $display("[%0t] error: %s", $realtime, what);
    endfunction

    function void check_score(logic [19:0] actual);
      logic [19:0] want;
      if (pending_scores.size() == 0) begin
        note_failure($sformatf("score %0d with no request waiting", actual));
        return;
      end
      want = pending_scores.pop_front();
      scores_checked++;
      if (actual !== want)
        note_failure($sformatf("score mismatch: expected %0d, actual %0d", want, actual));
    endfunction

    function int pending();
      return pending_scores.size();
    endfunction
  endclass

  move_score_board board;

  // idling knobs, percent per cycle
  int send_idle_pct;
  int recv_stall_pct;
  // long receiver hold-off: bump hold_seq to start one, hold_len sets its length
  int hold_seq;
  int hold_len;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // safety net in case the block hangs
  initial begin
    #(TIMEOUT_NS);
    $display("timeout with %0d scores outstanding", board.pending());
    $display("status: fail");
    $finish;
  end

  // receiver: random stalls, or a counted hold-off when one is requested
  initial begin : receiver
    int seen;
    int hold_left;
    seen      = 0;
    hold_left = 0;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_seq != seen) begin
        seen      = hold_seq;
        hold_left = hold_len;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // result monitor, samples pre-edge values
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) board.check_score(score_o);
  end

  // offer one request and hold it until accepted; entered and left right after an edge
  task automatic send_request(input logic [2:0] m, input int c, input int d);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    mode_i      <= m;
    cell_req_i  <= 8'(c);
    ply_depth_i <= 8'(d);
    do @(posedge clk_i); while (!(in_valid_i && in_ready_o));
    board.note_request(mode_i, cell_req_i, ply_depth_i);
  endtask

  // sender pauses until every score is back and the block has settled
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // mostly a small pool of cells and depths so killers and history actually hit
  task automatic send_random();
    logic [2:0] m;
    int         r;
    int         c;
    int         d;
    r = $urandom_range(0, 99);
    if (r < 28)      m = khmt_pkg::MODE_ADD_KILLER;
    else if (r < 52) m = khmt_pkg::MODE_ADD_HISTORY;
    else if (r < 54) m = khmt_pkg::MODE_AGE;
    else if (r < 88) m = khmt_pkg::MODE_SCORE;
    else if (r < 91) m = khmt_pkg::MODE_CLEAR;
    else             m = 3'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST));
    if ($urandom_range(0, 3) != 0) begin
      r = $urandom_range(0, 9);
      if (r == 8)      c = CELLS - 1;
      else if (r == 9) c = khmt_pkg::NO_MOVE;
      else             c = r;
    end else begin
      c = $urandom_range(0, 255);
    end
    if ($urandom_range(0, 3) != 0) begin
      r = $urandom_range(0, 4);
      d = (r == 4) ? DEPTH_SLOTS - 1 : r;
    end else begin
      d = int'($urandom_range(0, 255)) - 128;
    end
    send_request(m, c, d);
  endtask

  task automatic run_random(input int count);
    repeat (count) send_random();
  endtask

  // corner cases of the killer slots, history and the no-op modes
  task automatic run_directed();
    send_request(khmt_pkg::MODE_SCORE, 0, 0);                 // empty tables score zero
    send_request(khmt_pkg::MODE_SCORE, khmt_pkg::NO_MOVE, 0); // no-move never matches
    send_request(khmt_pkg::MODE_ADD_KILLER, 10, 0);
    send_request(khmt_pkg::MODE_SCORE, 10, 0);
    send_request(khmt_pkg::MODE_ADD_KILLER, 20, 0);           // shifts 10 into the second slot
    send_request(khmt_pkg::MODE_SCORE, 10, 0);
    send_request(khmt_pkg::MODE_SCORE, 20, 0);
    send_request(khmt_pkg::MODE_ADD_KILLER, 20, 0);           // already first, no shift
    send_request(khmt_pkg::MODE_ADD_KILLER, khmt_pkg::NO_MOVE, 0); // invalid cell ignored
    send_request(khmt_pkg::MODE_SCORE, 10, 0);
    send_request(khmt_pkg::MODE_ADD_KILLER, 30, DEPTH_SLOTS - 1);
    send_request(khmt_pkg::MODE_ADD_KILLER, 31, DEPTH_SLOTS); // depth past the table
    send_request(khmt_pkg::MODE_SCORE, 30, DEPTH_SLOTS - 1);
    send_request(khmt_pkg::MODE_ADD_KILLER, 40, -1);          // negative depth
    send_request(khmt_pkg::MODE_ADD_HISTORY, 5, -128);        // square of a negative depth
    send_request(khmt_pkg::MODE_ADD_HISTORY, CELLS - 1, 127);
    send_request(khmt_pkg::MODE_ADD_HISTORY, CELLS, 3);       // first cell past the board
    send_request(khmt_pkg::MODE_SCORE, 5, -128);
    send_request(khmt_pkg::MODE_AGE, 0, 0);
    send_request(khmt_pkg::MODE_SCORE, 5, 5);
    send_request(khmt_pkg::MODE_SCORE, CELLS - 1, 127);
    for (int m = MODE_SPARE_FIRST; m <= MODE_SPARE_LAST; m++)
      send_request(3'(m), $urandom_range(0, 255), int'($urandom_range(0, 255)) - 128);
    send_request(khmt_pkg::MODE_CLEAR, 0, 0);
    send_request(khmt_pkg::MODE_SCORE, 20, 0);
  endtask

  // drive one counter past saturation, then age it back below the cap
  task automatic run_saturation();
    for (int i = 0; i < 1040; i++) begin
      send_request(khmt_pkg::MODE_ADD_HISTORY, SAT_CELL,
                   ($urandom_range(0, 3) == 0) ? 127 : -128);
      if (i % 64 == 63) send_request(khmt_pkg::MODE_SCORE, SAT_CELL, -5);
    end
    repeat (6) begin
      send_request(khmt_pkg::MODE_AGE, 0, 0);
      send_request(khmt_pkg::MODE_SCORE, SAT_CELL, -5);
    end
  endtask

  initial begin : stimulus
    board          = new();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_seq       = 0;
    hold_len       = 0;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    mode_i      <= khmt_pkg::MODE_SCORE;
    cell_req_i  <= '0;
    ply_depth_i <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();

    // back to back in both directions
    run_random(225);

    // receiver holds off while scores keep coming, so the input backs up
    hold_len = 400;
    hold_seq++;
    repeat (40) send_request(khmt_pkg::MODE_SCORE, $urandom_range(0, 9), $urandom_range(0, 3));
    wait_drained();

    run_saturation();
    wait_drained();

    send_idle_pct  = 79;
    recv_stall_pct = 0;
    run_random(225);

    send_idle_pct  = 0;
    recv_stall_pct = 79;
    run_random(225);

    send_idle_pct  = 38;
    recv_stall_pct = 38;
    run_random(225);

    wait_drained();

    $display("summary: %0d requests, %0d scores checked, %0d killer adds, %0d history adds",
             board.requests, board.scores_checked, board.killer_adds, board.history_adds);
    $display("summary: %0d ages, %0d clears, counter saturation and a long output hold-off",
             board.ages, board.clears);
    if (board.failures == 0 && board.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d failures, %0d scores never returned", board.failures, board.pending());
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/khmt_pkg.sv
sv/khmt_ram.sv
sv/khmt_alu.sv
sv/killer_history_move_table_core.sv
sv/khmt_checker.sv
tb/tb_killer_history_move_table_core.sv
